[rtl/core/depth_sorted_insert_buffer_macros.svh]
`ifndef DEPTH_SORTED_INSERT_BUFFER_MACROS_SVH
`define DEPTH_SORTED_INSERT_BUFFER_MACROS_SVH
// same-cycle implication
`define DSIB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define DSIB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/dsib_pkg.sv]
`default_nettype none
package dsib_pkg;
  localparam int CAPACITY = 256;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] CFG_COEF_X = 2'd0;
  localparam logic [1:0] CFG_COEF_Y = 2'd1;
  localparam logic [1:0] CFG_COEF_Z = 2'd2;
  localparam logic [1:0] CFG_OFFSET = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       clr_acc;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       rnd;
    logic       srch_init;
    logic       srch_rd;
    logic       srch_upd;
    logic       shf_init;
    logic       shf_rd;
    logic       shf_wr;
    logic       ins_wr;
    logic       pop_rd;
    logic       pop_fin;
    logic       clr_list;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0]    func;
    logic          full;
    logic          empty;
    logic          srch_done;
    logic          shf_done;
    logic          out_busy;
    logic [CW-1:0] count;
  } sts_t;

  // logical list position to memory address, ring starting at head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(l);
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/core/dsib_if.sv]
`default_nettype none
interface dsib_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        tag_in;
  modport source (output valid, func, pos_x, pos_y, pos_z, tag_in, input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, tag_in, output ready);
endinterface

interface dsib_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        tag_out;
  logic signed [31:0] depth_out;
  logic [8:0]         entry_count;
  logic               accepted;
  logic               list_empty;
  modport source (output valid, tag_out, depth_out, entry_count, accepted, list_empty,
                  input ready);
  modport sink (input valid, tag_out, depth_out, entry_count, accepted, list_empty,
                output ready);
endinterface
`default_nettype wire

[rtl/core/dsib_ctrl.sv]
`default_nettype none
module dsib_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dsib_pkg::sts_t sts,
  output dsib_pkg::cmd_t     cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_M0     = 4'd2;
  localparam logic [3:0] S_M1     = 4'd3;
  localparam logic [3:0] S_M2     = 4'd4;
  localparam logic [3:0] S_RND    = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_SRD    = 4'd7;
  localparam logic [3:0] S_SCMP   = 4'd8;
  localparam logic [3:0] S_SHF_RD = 4'd9;
  localparam logic [3:0] S_SHF_WR = 4'd10;
  localparam logic [3:0] S_POPW   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.func)
          dsib_pkg::FUNC_INSERT: begin
            cmd.clr_acc = 1'b1;
            state_nxt = S_M0;
          end
          dsib_pkg::FUNC_POP: begin
            if (sts.empty) begin
              state_nxt = S_DONE;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt = S_POPW;
            end
          end
          dsib_pkg::FUNC_CLEAR: begin
            cmd.clr_list = 1'b1;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_M0: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel = 2'd0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel = 2'd1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel = 2'd2;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.full) begin
          state_nxt = S_DONE;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.srch_done) begin
          cmd.shf_init = 1'b1;
          state_nxt = S_SHF_RD;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt = S_SRD;
      end
      S_SHF_RD: begin
        if (sts.shf_done) begin
          cmd.ins_wr = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.shf_rd = 1'b1;
          state_nxt = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        cmd.shf_wr = 1'b1;
        state_nxt = S_SHF_RD;
      end
      S_POPW: begin
        cmd.pop_fin = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/core/dsib_dp.sv]
`default_nettype none
module dsib_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dsib_pkg::cmd_t     cmd,
  output dsib_pkg::sts_t          sts,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic [15:0]        in_tag,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [15:0]             out_tag,
  output logic signed [31:0]      out_depth,
  output logic [8:0]              out_count,
  output logic                    out_acc,
  output logic                    out_empty
);
  localparam int AW = dsib_pkg::AW;
  localparam int CW = dsib_pkg::CW;

  logic signed [31:0] coef_x_r, coef_y_r, coef_z_r, offset_r;
  logic [1:0]         func_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [15:0]        tag_r;
  logic signed [65:0] acc_r;
  logic signed [31:0] key_r;
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      count_r, lo_r, hi_r, idx_r;
  logic               ok_r;
  logic [31:0]        key_mem [dsib_pkg::CAPACITY];
  logic [15:0]        tag_mem [dsib_pkg::CAPACITY];
  logic [31:0]        rd_key_r;
  logic [15:0]        rd_tag_r;
  logic               out_valid_r;
  logic [15:0]        out_tag_r;
  logic signed [31:0] out_depth_r;
  logic [8:0]         out_count_r;
  logic               out_acc_r, out_empty_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [65:0] rnd_sum;
  logic [41:0]        rnd_q;
  logic signed [31:0] key_sat;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      rd_log;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic [31:0]        wr_key;
  logic [15:0]        wr_tag;
  logic [15:0]        res_tag;
  logic signed [31:0] res_depth;
  logic               res_acc, res_empty;

  always_comb begin
    case (cmd.mul_sel)
      2'd0: begin
        mul_a = coef_x_r;
        mul_b = px_r;
      end
      2'd1: begin
        mul_a = coef_y_r;
        mul_b = py_r;
      end
      default: begin
        mul_a = coef_z_r;
        mul_b = pz_r;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // round to nearest, ties up, then saturate
  assign rnd_sum = acc_r + 66'sd8388608;
  assign rnd_q = rnd_sum[65:24];
  always_comb begin
    if (rnd_q[41:31] == '0 || rnd_q[41:31] == '1) begin
      key_sat = rnd_q[31:0];
    end else if (rnd_q[41]) begin
      key_sat = 32'sh8000_0000;
    end else begin
      key_sat = 32'sh7fff_ffff;
    end
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = mid_sum[CW:1];

  always_comb begin
    if (cmd.srch_rd) begin
      rd_log = mid;
    end else if (cmd.shf_rd) begin
      rd_log = idx_r - CW'(1);
    end else begin
      rd_log = '0;
    end
  end
  assign rd_addr = dsib_pkg::phys(head_r, rd_log);

  always_comb begin
    wr_en = cmd.shf_wr | cmd.ins_wr;
    if (cmd.shf_wr) begin
      wr_addr = dsib_pkg::phys(head_r, idx_r);
      wr_key = rd_key_r;
      wr_tag = rd_tag_r;
    end else begin
      wr_addr = dsib_pkg::phys(head_r, lo_r);
      wr_key = key_r;
      wr_tag = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_rd | cmd.shf_rd | cmd.pop_rd) begin
      rd_key_r <= key_mem[rd_addr];
      rd_tag_r <= tag_mem[rd_addr];
    end
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_comb begin
    res_tag = '0;
    res_depth = '0;
    res_acc = 1'b0;
    res_empty = 1'b0;
    case (func_r)
      dsib_pkg::FUNC_INSERT: begin
        res_tag = tag_r;
        res_depth = key_r;
        res_acc = ok_r;
      end
      dsib_pkg::FUNC_POP: begin
        if (ok_r) begin
          res_tag = rd_tag_r;
          res_depth = rd_key_r;
          res_acc = 1'b1;
        end else begin
          res_empty = 1'b1;
        end
      end
      default: res_acc = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r <= '0;
      coef_y_r <= '0;
      coef_z_r <= 32'sd65536;
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dsib_pkg::CFG_COEF_X: coef_x_r <= cfg_data;
        dsib_pkg::CFG_COEF_Y: coef_y_r <= cfg_data;
        dsib_pkg::CFG_COEF_Z: coef_z_r <= cfg_data;
        dsib_pkg::CFG_OFFSET: offset_r <= cfg_data;
        default: offset_r <= offset_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      count_r <= '0;
      ok_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        ok_r <= 1'b0;
      end
      if (cmd.ins_wr) begin
        count_r <= count_r + CW'(1);
        ok_r <= 1'b1;
      end
      if (cmd.pop_fin) begin
        head_r <= dsib_pkg::phys(head_r, CW'(1));
        count_r <= count_r - CW'(1);
        ok_r <= 1'b1;
      end
      if (cmd.clr_list) begin
        count_r <= '0;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      pz_r <= in_pos_z;
      tag_r <= in_tag;
    end
    if (cmd.clr_acc) begin
      acc_r <= {{18{offset_r[31]}}, offset_r, 16'h0000};
    end else if (cmd.mul_step) begin
      acc_r <= acc_r + 66'(prod);
    end
    if (cmd.rnd) begin
      key_r <= key_sat;
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end else if (cmd.srch_upd) begin
      if ($signed(rd_key_r) >= key_r) begin
        lo_r <= mid + CW'(1);
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.shf_init) begin
      idx_r <= count_r;
    end else if (cmd.shf_wr) begin
      idx_r <= idx_r - CW'(1);
    end
    if (cmd.res_load) begin
      out_tag_r <= res_tag;
      out_depth_r <= res_depth;
      out_count_r <= 9'(count_r);
      out_acc_r <= res_acc;
      out_empty_r <= res_empty;
    end
  end

  assign sts.func = func_r;
  assign sts.full = (count_r == CW'(dsib_pkg::CAPACITY));
  assign sts.empty = (count_r == '0);
  assign sts.srch_done = (lo_r == hi_r);
  assign sts.shf_done = (idx_r == lo_r);
  assign sts.out_busy = out_valid_r & ~out_ready;
  assign sts.count = count_r;

  assign out_valid = out_valid_r;
  assign out_tag = out_tag_r;
  assign out_depth = out_depth_r;
  assign out_count = out_count_r;
  assign out_acc = out_acc_r;
  assign out_empty = out_empty_r;
endmodule
`default_nettype wire

[rtl/core/depth_sorted_insert_buffer.sv]
// depth-sorted billboard list, largest key at the front
// in_ch: one word per operation (func insert, pop front, clear); in_ch.ready is
//   high only while no operation is in progress
// out_ch: exactly one result word per input word, held in an output register
//   until out_ch.ready; the next input word is taken while it waits
// cfg_*: depth weights and offset, written while idle
// the key comes from one shared 32x32 multiplier, used for x, y and z in turn;
//   the binary search and the move of the tail entries each take a read and an
//   update state a step on the list memory, which is a ring so pop never moves
// reset empties the list and loads the default weights; no clearing pass
// a stalled receiver holds the finished result, and the block waits at the
//   end of the following operation until the output register is free
`default_nettype none
`include "depth_sorted_insert_buffer_macros.svh"
module depth_sorted_insert_buffer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dsib_in_if.sink          in_ch,
  dsib_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data
);
  dsib_pkg::cmd_t cmd;
  dsib_pkg::sts_t sts;

  dsib_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsib_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_func   (in_ch.func),
    .in_pos_x  (in_ch.pos_x),
    .in_pos_y  (in_ch.pos_y),
    .in_pos_z  (in_ch.pos_z),
    .in_tag    (in_ch.tag_in),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_tag   (out_ch.tag_out),
    .out_depth (out_ch.depth_out),
    .out_count (out_ch.entry_count),
    .out_acc   (out_ch.accepted),
    .out_empty (out_ch.list_empty)
  );

  `DSIB_ASSERT_NOW(a_cnt_range, 1'b1, sts.count <= dsib_pkg::CW'(dsib_pkg::CAPACITY), "count over capacity")
  `DSIB_ASSERT_NOW(a_res_free, cmd.res_load, !out_ch.valid || out_ch.ready, "result overwritten")
  `DSIB_ASSERT_NOW(a_pop_nonempty, cmd.pop_rd, !sts.empty, "pop read from empty list")
  `DSIB_ASSERT_NXT(a_ins_count, cmd.ins_wr, sts.count == $past(sts.count) + dsib_pkg::CW'(1), "insert count")
endmodule
`default_nettype wire

[tb/dsib_tb_pkg.sv]
`timescale 1ns / 100ps
package dsib_tb_pkg;
  import dsib_pkg::*;

  typedef struct packed {
    logic [15:0]        tag;
    logic signed [31:0] depth;
    logic [8:0]         count;
    logic               acc;
    logic               empty;
  } sort_result_t;

  // depth key: exact dot product in 2^-32 units, round half up, saturate
  function automatic logic signed [31:0] depth_key(
      input logic signed [31:0] cx, input logic signed [31:0] cy,
      input logic signed [31:0] cz, input logic signed [31:0] off,
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz);
    logic signed [79:0] acc;
    logic signed [79:0] q;
    acc = 80'(cx) * 80'(px) + 80'(cy) * 80'(py) + 80'(cz) * 80'(pz)
        + (80'(off) <<< 16) + 80'sd8388608;
    q = acc >>> 24;
    if (q > 80'sd2147483647) return 32'sh7fffffff;
    if (q < -80'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction
endpackage

[tb/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import dsib_pkg::*;
  import dsib_tb_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_data;

  dsib_in_if in_ch();
  dsib_out_if out_ch();

  depth_sorted_insert_buffer u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  logic signed [31:0] coef [4];
  logic signed [31:0] key_list [$];
  logic [15:0] tag_list [$];
  sort_result_t pending [$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("testbench: errors");
    $finish;
  end

  function automatic sort_result_t predict_sort(input logic [1:0] func,
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz, input logic [15:0] tag);
    sort_result_t r;
    int pos;
    r = '0;
    if (func == FUNC_INSERT) begin
      r.tag = tag;
      r.depth = depth_key(coef[0], coef[1], coef[2], coef[3], px, py, pz);
      if (key_list.size() < CAPACITY) begin
        pos = 0;
        while (pos < key_list.size() && key_list[pos] >= r.depth) pos++;
        key_list.insert(pos, r.depth);
        tag_list.insert(pos, tag);
        r.acc = 1;
      end
    end else if (func == FUNC_POP) begin
      if (key_list.size() == 0) begin
        r.empty = 1;
      end else begin
        r.tag = tag_list.pop_front();
        r.depth = key_list.pop_front();
        r.acc = 1;
      end
    end else if (func == FUNC_CLEAR) begin
      key_list.delete();
      tag_list.delete();
    end
    r.count = 9'(key_list.size());
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    coef[idx] = val;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // fixed result given: row checked against it instead of the predictor
  task automatic send_word(input logic [1:0] func, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] pz, input logic [15:0] tag,
      input bit fixed = 0, input sort_result_t want = '0);
    sort_result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.func <= func;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.tag_in <= tag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_sort(func, px, py, pz, tag);
    pending.push_back(fixed ? want : r);
  endtask

  always @(posedge clk) begin
    sort_result_t got;
    sort_result_t exp_r;
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.tag_out, out_ch.depth_out, out_ch.entry_count,
                out_ch.accepted, out_ch.list_empty};
        if (pending.size() == 0) begin
          $display("%t unexpected word: actual %h", $time, got);
          errors++;
        end else begin
          exp_r = pending.pop_front();
          if (got != exp_r) begin
            $display("%t mismatch: expected %h actual %h", $time, exp_r, got);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(2) == 0 ? 32'h80000000 : 32'h7fffffff;
    endcase
  endfunction

  typedef struct {
    logic [1:0] func;
    logic [31:0] px, py, pz;
    logic [15:0] tag;
    bit fixed;
    sort_result_t want;
  } stim_row_t;

  stim_row_t rows [] = '{
    '{FUNC_POP, 0, 0, 0, 0, 1, '{16'h0, 32'sh0, 9'd0, 1'b0, 1'b1}},
    '{FUNC_INSERT, 0, 0, 32'h00010000, 16'h1111, 1, '{16'h1111, 32'sh100, 9'd1, 1'b1, 1'b0}},
    '{FUNC_INSERT, 0, 0, 32'h7fffffff, 16'hffff, 1, '{16'hffff, 32'sh800000, 9'd2, 1'b1, 1'b0}},
    '{FUNC_INSERT, 0, 0, 32'h80000000, 16'h0000, 1, '{16'h0, 32'shff800000, 9'd3, 1'b1, 1'b0}},
    '{FUNC_INSERT, 32'hffffffff, 32'hffffffff, 32'h00010000, 16'h2222, 0, '0},
    '{FUNC_INSERT, 0, 0, 32'h00000080, 16'h3333, 0, '0},
    '{FUNC_INSERT, 0, 0, 32'h0000007f, 16'h4444, 0, '0},
    '{FUNC_POP, 0, 0, 0, 0, 1, '{16'hffff, 32'sh800000, 9'd5, 1'b1, 1'b0}},
    '{FUNC_POP, 0, 0, 0, 0, 0, '0},
    '{FUNC_POP, 0, 0, 0, 0, 0, '0},
    '{2'd3, 32'h12345678, 0, 0, 16'h5555, 1, '{16'h0, 32'sh0, 9'd3, 1'b0, 1'b0}},
    '{FUNC_CLEAR, 0, 0, 0, 0, 1, '{16'h0, 32'sh0, 9'd0, 1'b0, 1'b0}},
    '{FUNC_POP, 0, 0, 0, 0, 1, '{16'h0, 32'sh0, 9'd0, 1'b0, 1'b1}}
  };

  initial begin
    int n;
    int phase;
    int lim;
    logic [1:0] f;
    in_ch.valid = 0;
    in_ch.func = FUNC_INSERT;
    in_ch.pos_x = 0;
    in_ch.pos_y = 0;
    in_ch.pos_z = 0;
    in_ch.tag_in = 0;
    out_ch.ready = 0;
    cfg_we = 0;
    cfg_idx = CFG_COEF_X;
    cfg_data = 0;
    coef[0] = 0;
    coef[1] = 0;
    coef[2] = 32'sd65536;
    coef[3] = 0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[i])
      send_word(rows[i].func, rows[i].px, rows[i].py, rows[i].pz, rows[i].tag,
                rows[i].fixed, rows[i].want);
    drain();

    // fill to capacity with duplicate keys, overflow, then pop 40 and clear
    for (int i = 0; i < CAPACITY + 3; i++)
      send_word(FUNC_INSERT, 0, 0, 32'($urandom_range(40)) <<< 16, 16'(i));
    for (int i = 0; i < 40; i++) send_word(FUNC_POP, 0, 0, 0, 0);
    send_word(FUNC_CLEAR, 0, 0, 0, 0);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_COEF_X, 32'h7fffffff); write_reg(CFG_COEF_Y, 32'h80000000);
          write_reg(CFG_COEF_Z, 32'h7fffffff); write_reg(CFG_OFFSET, 32'h80000000);
        end
        1: begin
          write_reg(CFG_COEF_X, 32'h80000000); write_reg(CFG_COEF_Y, 32'h7fffffff);
          write_reg(CFG_COEF_Z, 32'h80000000); write_reg(CFG_OFFSET, 32'h7fffffff);
        end
        default: begin
          write_reg(CFG_COEF_X, $urandom >> $urandom_range(31));
          write_reg(CFG_COEF_Y, $urandom >> $urandom_range(31));
          write_reg(CFG_COEF_Z, $urandom >> $urandom_range(31));
          write_reg(CFG_OFFSET, $urandom);
        end
      endcase
      cfg_we <= 0;
      send_idle = (phase < 2) ? 16 : (phase < 4) ? 82 : 0;
      recv_idle = (phase < 2) ? 82 : (phase < 4) ? 16 : 0;
      lim = 265;
      for (n = 0; n < lim; n++) begin
        case ($urandom_range(19))
          0: f = FUNC_CLEAR;
          1: f = 2'd3;
          2, 3, 4, 5, 6, 7: f = FUNC_POP;
          default: f = FUNC_INSERT;
        endcase
        // keep lists mostly short so inserts stay quick
        if (key_list.size() > 24 && f == FUNC_INSERT && $urandom_range(1)) f = FUNC_POP;
        send_word(f, rand_pos(), rand_pos(), rand_pos(), 16'($urandom));
        if (n == 150) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/dsib_pkg.sv
rtl/core/dsib_if.sv
rtl/core/dsib_ctrl.sv
rtl/core/dsib_dp.sv
rtl/core/depth_sorted_insert_buffer.sv
tb/dsib_tb_pkg.sv
tb/testbench.sv
